FILE: sv/wsta_pkg.sv
package wsta_pkg;

  localparam int SRV_NUM_DEF = 16;
  localparam int SRV_IDX_W   = 8;
  localparam int CNT_W       = 9;
  localparam int WEIGHT_W    = 20;
  localparam int DUR_W       = 20;
  localparam int TIME_W      = 48;
  localparam int CFG_W       = 5;
  localparam int OUT_IDX_W   = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [CFG_W-1:0]  ACTIVE_RESET = CFG_W'(16);

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TASK = 1'b1;

  typedef struct packed {
    logic                  vld;
    logic [TIME_W-1:0]     now;
    logic                  any_free;
    logic [SRV_IDX_W-1:0]  free_idx;
    logic [WEIGHT_W-1:0]   free_w;
    logic                  have;
    logic [SRV_IDX_W-1:0]  best_idx;
    logic [TIME_W-1:0]     best_ft;
    logic [WEIGHT_W-1:0]   best_w;
  } tok_t;

  typedef struct packed {
    logic                  clr;
    logic                  ld;
    logic [WEIGHT_W-1:0]   ld_w;
    logic                  upd;
    logic [TIME_W-1:0]     upd_ft;
  } cell_ctl_t;

endpackage

FILE: sv/wsta_cell.sv
module wsta_cell
  import wsta_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 act,
  input  logic [SRV_IDX_W-1:0] idx,
  input  cell_ctl_t            ctl,
  input  tok_t                 tok_in,
  output tok_t                 tok_out
);

  logic [WEIGHT_W-1:0] weight;
  logic [TIME_W-1:0]   free_time;
  tok_t                tok_q;
  tok_t                tok_next;

  always_comb begin
    tok_next = tok_in;
    if (tok_in.vld && act) begin
      if (free_time <= tok_in.now && (!tok_in.any_free || weight < tok_in.free_w)) begin
        tok_next.any_free = 1'b1;
        tok_next.free_idx = idx;
        tok_next.free_w   = weight;
      end
      if (!tok_in.have || free_time < tok_in.best_ft ||
          (free_time == tok_in.best_ft && weight < tok_in.best_w)) begin
        tok_next.have     = 1'b1;
        tok_next.best_idx = idx;
        tok_next.best_ft  = free_time;
        tok_next.best_w   = weight;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight    <= '0;
      free_time <= '0;
    end else begin
      if (ctl.ld) begin
        weight <= ctl.ld_w;
      end
      if (ctl.clr) begin
        free_time <= '0;
      end else if (ctl.upd) begin
        free_time <= ctl.upd_ft;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q.vld <= 1'b0;
    end else if (adv) begin
      tok_q <= tok_next;
    end
  end

  assign tok_out = tok_q;

endmodule

FILE: sv/weighted_server_task_assigner_unit.sv
// Task flow: the search token crosses one cell per cycle through the chain; when the
// result register is free, the tail writes back the chosen server's free time.
// Only one task is in flight: in_stall holds new tasks until the result is registered;
// a weight load is accepted only while idle.
// Reset (rst, synchronous): weights, free times and task clock cleared,
// active_servers set to 16, no result pending.
module weighted_server_task_assigner_unit
  import wsta_pkg::*;
#(
  parameter int NUM_SERVERS = SRV_NUM_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 func,
  input  logic [3:0]           server_slot,
  input  logic [WEIGHT_W-1:0]  server_weight,
  input  logic [DUR_W-1:0]     task_duration,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_IDX_W-1:0] chosen_server,
  output logic [TIME_W-1:0]    finish_time
);

  logic [CFG_W-1:0]       active_servers;
  logic [CNT_W-1:0]       act_n;
  logic                   busy;
  logic [DUR_W-1:0]       dur;
  logic [TIME_W-1:0]      task_clock;
  logic                   in_xfer;
  logic                   task_xfer;
  logic                   load_xfer;
  logic                   done;
  logic                   adv;
  tok_t                   inj;
  tok_t                   tl;
  tok_t                   toks [NUM_SERVERS];
  cell_ctl_t              ctls [NUM_SERVERS];
  logic [NUM_SERVERS-1:0] act;
  logic [NUM_SERVERS-1:0] tok_vld;
  logic [SRV_IDX_W-1:0]   pick;
  logic [TIME_W-1:0]      base;
  logic [TIME_W:0]        sum;
  logic [TIME_W-1:0]      fin;

  assign in_stall  = busy;
  assign in_xfer   = in_valid && !in_stall;
  assign task_xfer = in_xfer && (func == FUNC_TASK);
  assign load_xfer = in_xfer && (func == FUNC_LOAD);

  always_comb begin
    if (active_servers == '0) begin
      act_n = CNT_W'(1);
    end else if (CNT_W'(active_servers) > CNT_W'(NUM_SERVERS)) begin
      act_n = CNT_W'(NUM_SERVERS);
    end else begin
      act_n = CNT_W'(active_servers);
    end
  end

  always_comb begin
    inj     = '0;
    inj.vld = task_xfer;
    inj.now = task_clock;
  end

  assign tl   = toks[NUM_SERVERS-1];
  assign done = tl.vld && (!out_valid || !out_stall);
  assign adv  = !tl.vld || done;
  assign pick = tl.any_free ? tl.free_idx : tl.best_idx;
  assign base = tl.any_free ? tl.now : tl.best_ft;
  assign sum  = {1'b0, base} + (TIME_W + 1)'(dur);
  assign fin  = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

  for (genvar i = 0; i < NUM_SERVERS; i++) begin : g_cell
    assign act[i]     = CNT_W'(i) < act_n;
    assign tok_vld[i] = toks[i].vld;

    always_comb begin
      ctls[i].clr    = load_xfer;
      ctls[i].ld     = load_xfer && ({{(SRV_IDX_W-4){1'b0}}, server_slot} == SRV_IDX_W'(i));
      ctls[i].ld_w   = server_weight;
      ctls[i].upd    = done && (pick == SRV_IDX_W'(i));
      ctls[i].upd_ft = fin;
    end

    if (i == 0) begin : g_head
      wsta_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .adv    (adv),
        .act    (act[i]),
        .idx    (SRV_IDX_W'(i)),
        .ctl    (ctls[i]),
        .tok_in (inj),
        .tok_out(toks[i])
      );
    end else begin : g_body
      wsta_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .adv    (adv),
        .act    (act[i]),
        .idx    (SRV_IDX_W'(i)),
        .ctl    (ctls[i]),
        .tok_in (toks[i-1]),
        .tok_out(toks[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_servers <= ACTIVE_RESET;
      busy           <= 1'b0;
      task_clock     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        active_servers <= cfg_wr_data;
      end
      if (task_xfer) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (load_xfer) begin
        task_clock <= '0;
      end else if (done && task_clock != TIME_MAX) begin
        task_clock <= task_clock + TIME_W'(1);
      end
      if (done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (task_xfer) begin
      dur <= task_duration;
    end
    if (done) begin
      chosen_server <= pick[OUT_IDX_W-1:0];
      finish_time   <= fin;
    end
  end

`ifndef SYNTH
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_vld))
    else $error("more than one search token in the chain");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> tok_vld == '0)
    else $error("search token present while idle");

  a_done_output: assert property (@(posedge clk) disable iff (rst)
    done |=> out_valid)
    else $error("finished task not presented");

  a_clock_step: assert property (@(posedge clk) disable iff (rst)
    done |=> (task_clock != $past(task_clock) || $past(task_clock) == TIME_MAX))
    else $error("task clock did not advance");

  a_finish_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> fin >= base)
    else $error("finish time below base time");
`endif

endmodule
